// File: rtl/tfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the temperature frame checker: status codes,
// register indexes, the queued frame record and the calibration constants.
// ----------------------------------------------------------------------------
package tfc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OFF = 2'd1,
    ST_ERR = 2'd2
  } status_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 8'd3;
  localparam int unsigned CFG_DATA_W = 24;

  // reset values of the registers
  localparam logic        RST_ENABLE   = 1'b0;
  localparam logic [15:0] RST_GAIN     = 16'd4096;
  localparam logic [23:0] RST_OFFSET   = 24'd0;
  localparam logic [7:0]  RST_CRC_POLY = 8'h31;

  // low byte keeps its upper six bits, the two status bits are dropped
  localparam logic [7:0] RAW_MASK = 8'b1111_1100;

  // queue between classifier and converter
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // classified frame as it travels through the queue
  typedef struct packed {
    status_t     status;
    logic [15:0] raw;
  } item_t;

  // celsius*100*2^16 = 17572*raw - 4685*2^16
  localparam logic [14:0]        CAL_SLOPE = 15'd17572;
  localparam logic signed [31:0] CAL_BASE  = 32'sd307036160;

  // 2n + 100*2^20 (round half up) plus 25*2^43 so that the sum stays positive;
  // bits 48..23 then hold floor(.../2^23) + 25*2^20
  localparam logic [49:0] CAL_K = 50'd219902430412800;

  // floor(u/25) = (u*RECIP) >> 31, exact while 2*u < 2^31
  localparam logic [26:0] RECIP_25 = 27'd85899346;

  // the bias above leaves 2^20 on the quotient
  localparam logic signed [25:0] Q_BIAS = 26'sd1048576;

  localparam logic signed [25:0] T_MAX = 26'sd8388607;
  localparam logic signed [25:0] T_MIN = -26'sd8388608;

endpackage

// File: rtl/tfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_front
// Takes frames, runs the CRC-8 over the three bytes one byte per stage and
// classifies each frame as ok, not enabled or error before queueing it.
// ----------------------------------------------------------------------------
module tfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic [7:0]          crc_poly,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          high_byte,
  input  logic [7:0]          low_byte,
  input  logic [7:0]          check_byte,
  input  logic                bus_ok,
  output logic                push,
  output tfc_pkg::item_t      push_item,
  input  logic                full
);

  // one byte through the msb-first crc-8
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                          input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic       v1, v2;
  logic       adv1, adv2;
  logic [7:0] hi1, lo1, ck1, crc1;
  logic       ok1;
  logic [7:0] hi2, lo2, ck2, crc2;
  logic       ok2;
  logic [7:0] crc3;

  // stage ready chain
  assign adv2     = !v2 || !full;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign push     = v2 && !full;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  // stage 1: capture transfer, crc over high byte
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      hi1  <= high_byte;
      lo1  <= low_byte;
      ck1  <= check_byte;
      ok1  <= bus_ok;
      crc1 <= crc_byte(8'd0, high_byte, crc_poly);
    end
  end

  // stage 2: crc over low byte
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      hi2  <= hi1;
      lo2  <= lo1;
      ck2  <= ck1;
      ok2  <= ok1;
      crc2 <= crc_byte(crc1, lo1, crc_poly);
    end
  end

  // check byte and classification into the queue
  always_comb begin
    crc3 = crc_byte(crc2, ck2, crc_poly);
    push_item.raw = 16'd0;
    if (!enable) begin
      push_item.status = tfc_pkg::ST_OFF;
    end else if (!ok2 || crc3 != 8'd0) begin
      push_item.status = tfc_pkg::ST_ERR;
    end else begin
      push_item.status = tfc_pkg::ST_OK;
      push_item.raw    = {hi2, lo2 & tfc_pkg::RAW_MASK};
    end
  end

endmodule

// File: rtl/tfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_queue
// Small first-in first-out queue of classified frames between the
// classifier and the converter.
// ----------------------------------------------------------------------------
module tfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tfc_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output tfc_pkg::item_t rd_item,
  output logic           not_empty
);

  tfc_pkg::item_t               mem [tfc_pkg::QDEPTH];
  logic [tfc_pkg::QAW-1:0]      wr_ptr, rd_ptr;
  logic [tfc_pkg::QAW:0]        count;

  assign full      = (count == (tfc_pkg::QAW+1)'(tfc_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (tfc_pkg::QAW+1)'(tfc_pkg::QDEPTH))
    else $error("queue fill level above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill level did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue fill level did not shrink on pop");

endmodule

// File: rtl/tfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_back
// Converts queued frames to calibrated Q16.8 celsius: slope multiply, gain
// multiply, rounding, divide by 25 through a reciprocal, offset and clipping.
// ----------------------------------------------------------------------------
module tfc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] gain,
  input  logic signed [23:0] offset,
  input  logic               head_valid,
  input  tfc_pkg::item_t     head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [15:0]        raw_value,
  output logic signed [23:0] temperature,
  output logic               saturated
);

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  tfc_pkg::item_t it1, it2, it3, it4;
  logic signed [31:0] m1;
  logic signed [47:0] n2;
  logic [25:0]        u3;
  logic [20:0]        q4;

  logic [30:0]        slope_prod;
  logic signed [31:0] m_next;
  logic signed [47:0] n_next;
  logic [49:0]        x_sum;
  logic [52:0]        recip_prod;
  logic signed [25:0] t_sum;
  logic signed [23:0] t_next;
  logic               sat_next;

  // stage ready chain
  assign adv5 = !v5 || out_ready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pop  = head_valid && adv1;
  assign out_valid = v5;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= head_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // datapath arithmetic per stage
  always_comb begin
    slope_prod = 31'(head_item.raw) * 31'(tfc_pkg::CAL_SLOPE);
    m_next     = $signed({1'b0, slope_prod}) - tfc_pkg::CAL_BASE;
    n_next     = gain * m1;
    x_sum      = {n2[47], n2, 1'b0} + tfc_pkg::CAL_K;
    recip_prod = 53'(u3) * 53'(tfc_pkg::RECIP_25);
    t_sum      = $signed({5'b0, q4}) - tfc_pkg::Q_BIAS + 26'(offset);
    sat_next   = 1'b0;
    if (t_sum > tfc_pkg::T_MAX) begin
      t_next   = 24'(tfc_pkg::T_MAX);
      sat_next = 1'b1;
    end else if (t_sum < tfc_pkg::T_MIN) begin
      t_next   = 24'(tfc_pkg::T_MIN);
      sat_next = 1'b1;
    end else begin
      t_next   = 24'(t_sum);
    end
  end

  // stage 1: scaled celsius numerator
  always_ff @(posedge clk) begin
    if (pop) begin
      it1 <= head_item;
      m1  <= m_next;
    end
  end

  // stage 2: gain multiply
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      it2 <= it1;
      n2  <= n_next;
    end
  end

  // stage 3: round half up and drop 23 bits
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      it3 <= it2;
      u3  <= x_sum[48:23];
    end
  end

  // stage 4: divide by 25
  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      it4 <= it3;
      q4  <= recip_prod[51:31];
    end
  end

  // stage 5: offset, clip and result register
  always_ff @(posedge clk) begin
    if (adv5 && v4) begin
      status <= it4.status;
      if (it4.status == tfc_pkg::ST_OK) begin
        raw_value   <= it4.raw;
        temperature <= t_next;
        saturated   <= sat_next;
      end else begin
        raw_value   <= 16'd0;
        temperature <= 24'sd0;
        saturated   <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/temperature_frame_checker.sv
`timescale 1ns / 1ps
// Path: a transferred frame passes 2 classifier stages, the queue, 4 converter
// stages and the result register before its result shows.
// Throughput: one frame per cycle, held only by backpressure on the result side.
// Reset: rst clears all stage valid flags, empties the queue and restores the
// registers to enable 0, gain 4096, offset 0, crc_poly 0x31.
// ----------------------------------------------------------------------------
// temperature_frame_checker
// Checks three-byte sensor frames by CRC-8 and converts the measurement to a
// calibrated, saturated Q16.8 celsius value.
// ----------------------------------------------------------------------------
module temperature_frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    high_byte,
  input  logic [7:0]                    low_byte,
  input  logic [7:0]                    check_byte,
  input  logic                          bus_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [15:0]                   raw_value,
  output logic signed [23:0]            temperature,
  output logic                          saturated
);

  logic               enable;
  logic signed [15:0] gain;
  logic signed [23:0] offset;
  logic [7:0]         crc_poly;

  logic           push, full, pop, not_empty;
  tfc_pkg::item_t push_item, head_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= tfc_pkg::RST_ENABLE;
      gain     <= tfc_pkg::RST_GAIN;
      offset   <= tfc_pkg::RST_OFFSET;
      crc_poly <= tfc_pkg::RST_CRC_POLY;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfc_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
        tfc_pkg::CFG_GAIN:     gain     <= cfg_data[15:0];
        tfc_pkg::CFG_OFFSET:   offset   <= cfg_data[23:0];
        tfc_pkg::CFG_CRC_POLY: crc_poly <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // classifier
  tfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .crc_poly   (crc_poly),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .high_byte  (high_byte),
    .low_byte   (low_byte),
    .check_byte (check_byte),
    .bus_ok     (bus_ok),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  // decoupling queue
  tfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (push_item),
    .full      (full),
    .pop       (pop),
    .rd_item   (head_item),
    .not_empty (not_empty)
  );

  // converter
  tfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .gain        (gain),
    .offset      (offset),
    .head_valid  (not_empty),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .raw_value   (raw_value),
    .temperature (temperature),
    .saturated   (saturated)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tfc_pkg::ST_OK |->
      raw_value == 16'd0 && temperature == 24'sd0 && !saturated)
    else $error("failed frame carries nonzero result fields");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      temperature == 24'sh7FFFFF || temperature == 24'sh800000)
    else $error("saturated result not at a rail");

  a_raw_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tfc_pkg::ST_OK |-> raw_value[1:0] == 2'b00)
    else $error("status bits not masked from raw value");

endmodule
